### hw/rtl/ipv4_route_prefix_lookup_assert.svh
// Assertion macros for the route prefix lookup block
`ifndef IPV4_ROUTE_PREFIX_LOOKUP_ASSERT_SVH
`define IPV4_ROUTE_PREFIX_LOOKUP_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define IPRL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipv4_route_prefix_lookup: check failed");

// check the consequent in the cycle after the antecedent
`define IPRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipv4_route_prefix_lookup: check failed");

`endif

### hw/rtl/iprl_pkg.sv
// Shared types, codes and helper functions of the route prefix lookup block
package iprl_pkg;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 48;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic [31:0] lookup_addr;
    logic        entry_enable;
    logic [2:0]  route_port;
    logic [31:0] route_mask;
    logic [31:0] route_prefix;
    logic [3:0]  entry_slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic [5:0]  prefix_len;
    logic [31:0] next_hop_addr;
    logic [2:0]  out_port;
    logic [3:0]  match_slot;
  } out_item_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [2:0]  port;
  } entry_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  slot;
    logic [2:0]  port;
    logic [31:0] next_hop;
    logic [5:0]  len;
  } res_t;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_READ,
    SCAN_DRAIN,
    SCAN_DONE
  } scan_state_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

  function automatic logic [5:0] pop32(input logic [31:0] v);
    logic [5:0] n;
    n = {2'd0, pop8(v[7:0])} + {2'd0, pop8(v[15:8])}
      + {2'd0, pop8(v[23:16])} + {2'd0, pop8(v[31:24])};
    return n;
  endfunction

endpackage

### hw/rtl/ipv4_route_prefix_lookup.sv
// Top level of the IPv4 longest-prefix route lookup block
//
// One input stream carries two kinds of item, told apart by in_tuser:
// a route write (in_tuser = 0) stores prefix, mask and port in a table
// slot and sets or clears its valid mark; a lookup (in_tuser = 1) gives
// a destination address. A write gives no result; a write to a slot
// or with a port beyond the table or port count is dropped. A lookup
// reads the table memory one entry per cycle, as the route memory has
// a single read port. One lookup is in flight at a time; in_tready is
// low while it runs.
// The result stream gives one item per lookup: out_tuser found, in
// out_tdata the best slot, port, stored prefix and prefix length, all
// zero when no valid entry matches. A stalled result is held in the
// output register while the next lookup runs; the finished scan then
// waits for the register to free up. Reset clears all valid marks at
// once and empties the output register; the route memory is not cleared.
module ipv4_route_prefix_lookup #(
  parameter int ROUTE_ENTRIES = 16,
  parameter int PORT_COUNT    = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // entry_slot, route_prefix, route_mask, route_port, entry_enable, lookup_addr
  input  logic [iprl_pkg::IN_TDATA_W-1:0]    in_tdata,
  // req_type
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // match_slot, out_port, next_hop_addr, prefix_len, zero fill
  output logic [iprl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // found
  output logic                               out_tuser
);

  localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

  iprl_pkg::in_item_t   item;
  iprl_pkg::entry_t     wr_entry;
  iprl_pkg::entry_t     rd_entry;
  iprl_pkg::res_t       res;
  iprl_pkg::out_item_t  out_item;
  logic                 accept;
  logic                 wr_en;
  logic                 start;
  logic                 idle;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_mark;
  logic                 res_valid;
  logic                 res_ready;
  logic                 out_tvalid_r;
  logic [iprl_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                 out_tuser_r;

  assign item      = iprl_pkg::in_item_t'(in_tdata);
  assign in_tready = idle;
  assign accept    = in_tvalid && in_tready;

  assign wr_en = accept && (in_tuser == iprl_pkg::REQ_WRITE) &&
                 (32'(item.entry_slot) < 32'(ROUTE_ENTRIES)) &&
                 (32'(item.route_port) < 32'(PORT_COUNT));
  assign start = accept && (in_tuser == iprl_pkg::REQ_LOOKUP);

  assign wr_entry.prefix = item.route_prefix;
  assign wr_entry.mask   = item.route_mask;
  assign wr_entry.port   = item.route_port;

  iprl_table #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_idx  (IDX_W'(item.entry_slot)),
    .wr_entry(wr_entry),
    .wr_mark (item.entry_enable),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_entry(rd_entry),
    .rd_mark (rd_mark)
  );

  iprl_scan #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .lookup_addr(item.lookup_addr),
    .idle       (idle),
    .rd_en      (rd_en),
    .rd_idx     (rd_idx),
    .rd_entry   (rd_entry),
    .rd_mark    (rd_mark),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_item               = '0;
    out_item.match_slot    = res.slot;
    out_item.out_port      = res.port;
    out_item.next_hop_addr = res.next_hop;
    out_item.prefix_len    = res.len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_tdata_r <= out_item;
      out_tuser_r <= res.found;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

### hw/rtl/iprl_table.sv
// Route table memory with one write port, one registered read port and valid marks
module iprl_table #(
  parameter int ROUTE_ENTRIES = 16,
  parameter int IDX_W         = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  iprl_pkg::entry_t     wr_entry,
  input  logic                 wr_mark,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_idx,
  output iprl_pkg::entry_t     rd_entry,
  output logic                 rd_mark
);

  iprl_pkg::entry_t           mem [ROUTE_ENTRIES];
  logic [ROUTE_ENTRIES-1:0]   valid_r;
  iprl_pkg::entry_t           rd_entry_r;
  logic                       rd_mark_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem[rd_idx];
      rd_mark_r  <= valid_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= wr_mark;
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_mark  = rd_mark_r;

endmodule

### hw/rtl/iprl_scan.sv
// Lookup sequencer: sweep the table, compare each entry and keep the longest match
module iprl_scan #(
  parameter int ROUTE_ENTRIES = 16,
  parameter int IDX_W         = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [31:0]          lookup_addr,
  output logic                 idle,
  output logic                 rd_en,
  output logic [IDX_W-1:0]     rd_idx,
  input  iprl_pkg::entry_t     rd_entry,
  input  logic                 rd_mark,
  output logic                 res_valid,
  input  logic                 res_ready,
  output iprl_pkg::res_t       res
);

  iprl_pkg::scan_state_t state_r, state_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic [31:0]           addr_r;
  logic                  rd_last;

  logic                  s1_vld_r, s1_last_r;
  logic [IDX_W-1:0]      s1_idx_r;

  logic                  s2_vld_r, s2_last_r;
  logic                  s2_match_r;
  logic [5:0]            s2_len_r;
  logic [IDX_W-1:0]      s2_idx_r;
  logic [31:0]           s2_prefix_r;
  logic [2:0]            s2_port_r;

  logic                  have_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [5:0]            best_len_r;
  logic [31:0]           best_prefix_r;
  logic [2:0]            best_port_r;
  logic                  take;

  assign rd_last = (state_r == iprl_pkg::SCAN_READ) &&
                   (cnt_r == IDX_W'(ROUTE_ENTRIES - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      iprl_pkg::SCAN_IDLE: begin
        if (start) begin
          state_nxt = iprl_pkg::SCAN_READ;
        end
      end
      iprl_pkg::SCAN_READ: begin
        if (rd_last) begin
          state_nxt = iprl_pkg::SCAN_DRAIN;
        end
      end
      iprl_pkg::SCAN_DRAIN: begin
        if (s2_vld_r && s2_last_r) begin
          state_nxt = iprl_pkg::SCAN_DONE;
        end
      end
      iprl_pkg::SCAN_DONE: begin
        if (res_ready) begin
          state_nxt = iprl_pkg::SCAN_IDLE;
        end
      end
      default: state_nxt = iprl_pkg::SCAN_IDLE;
    endcase
  end

  always_comb begin
    idle      = 1'b0;
    rd_en     = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      iprl_pkg::SCAN_IDLE:  idle      = 1'b1;
      iprl_pkg::SCAN_READ:  rd_en     = 1'b1;
      iprl_pkg::SCAN_DRAIN: rd_en     = 1'b0;
      iprl_pkg::SCAN_DONE:  res_valid = 1'b1;
      default:              idle      = 1'b0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (start) begin
      cnt_nxt = '0;
    end else if (state_r == iprl_pkg::SCAN_READ) begin
      cnt_nxt = cnt_r + IDX_W'(1);
    end
  end

  assign rd_idx = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= iprl_pkg::SCAN_IDLE;
      cnt_r     <= '0;
      s1_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
      s2_vld_r  <= 1'b0;
      s2_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      s1_vld_r  <= rd_en;
      s1_last_r <= rd_last;
      s2_vld_r  <= s1_vld_r;
      s2_last_r <= s1_last_r;
    end
  end

  // compare stage: masked match and prefix length
  always_ff @(posedge clk) begin
    if (start) begin
      addr_r <= lookup_addr;
    end
    s1_idx_r    <= cnt_r;
    s2_idx_r    <= s1_idx_r;
    s2_match_r  <= rd_mark &&
                   (((addr_r ^ rd_entry.prefix) & rd_entry.mask) == 32'd0);
    s2_len_r    <= iprl_pkg::pop32(rd_entry.mask);
    s2_prefix_r <= rd_entry.prefix;
    s2_port_r   <= rd_entry.port;
  end

  // keep the longest match, lowest slot on a tie
  assign take = s2_vld_r && s2_match_r && (!have_r || (s2_len_r > best_len_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (start) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r    <= s2_idx_r;
      best_len_r    <= s2_len_r;
      best_prefix_r <= s2_prefix_r;
      best_port_r   <= s2_port_r;
    end
  end

  always_comb begin
    res = '0;
    if (have_r) begin
      res.found    = 1'b1;
      res.slot     = 4'(best_idx_r);
      res.port     = best_port_r;
      res.next_hop = best_prefix_r;
      res.len      = best_len_r;
    end
  end

endmodule

### hw/rtl/iprl_checker.sv
// Port-level checks of the route prefix lookup block and their bind
`include "ipv4_route_prefix_lookup_assert.svh"

module iprl_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [iprl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                               out_tuser
);

  `IPRL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `IPRL_ASSERT_NOW(a_miss_zero, out_tvalid && !out_tuser, out_tdata == '0)
  `IPRL_ASSERT_NOW(a_len_range, out_tvalid, out_tdata[44:39] <= 6'd32)
  `IPRL_ASSERT_NEXT(a_lookup_busy, in_tvalid && in_tready && (in_tuser == iprl_pkg::REQ_LOOKUP), !in_tready)

endmodule

bind ipv4_route_prefix_lookup iprl_checker u_iprl_checker (.*);
